/* design/segment_intersection_q16_unit_assert.svh */
// Assertion macros for the segment intersection unit checker.
`ifndef SEGMENT_INTERSECTION_Q16_UNIT_ASSERT_SVH
`define SEGMENT_INTERSECTION_Q16_UNIT_ASSERT_SVH

// clocked check, muted while reset is held
`define SIA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define SIA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/sia_pkg.sv */
// Shared widths, payload type and defaults for the segment intersection unit.
package sia_pkg;

  localparam int XW            = 32;  // coordinate width
  localparam int DW            = XW + 1;  // exact difference width
  localparam int PW            = 2 * DW;  // exact product width
  localparam int FRAC_BITS_DEF = 16;
  localparam int QDEPTH        = 4;

  typedef logic signed [XW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;

  // values that ride along to the interpolation step
  typedef struct packed {
    coord_t x1;
    coord_t y1;
    diff_t  dax;
    diff_t  day;
  } pay_t;

endpackage

/* design/sia_mul.sv */
// Two-stage exact signed multiplier built from narrow partial products.
module sia_mul (
  input  logic                         clk,
  input  logic                         en,
  input  sia_pkg::diff_t               a,
  input  sia_pkg::diff_t               b,
  output logic signed [sia_pkg::PW-1:0] p
);
  import sia_pkg::*;

  localparam int LB = 17;
  localparam int HB = DW - LB;

  logic signed [HB-1:0]    ah, bh;
  logic signed [LB:0]      al, bl;
  logic signed [2*HB-1:0]  hh_r;
  logic signed [HB+LB:0]   hl_r, lh_r;
  logic signed [2*LB+1:0]  ll_r;
  logic signed [PW-1:0]    p_r;

  assign ah = a[DW-1:LB];
  assign bh = b[DW-1:LB];
  assign al = $signed({1'b0, a[LB-1:0]});
  assign bl = $signed({1'b0, b[LB-1:0]});

  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= ah * bh;
      hl_r <= ah * bl;
      lh_r <= al * bh;
      ll_r <= al * bl;
      p_r  <= (PW'(hh_r) <<< (2 * LB)) + ((PW'(hl_r) + PW'(lh_r)) <<< LB) + PW'(ll_r);
    end
  end

  assign p = p_r;

endmodule

/* design/sia_fifo.sv */
// Small register queue between the front and back sections.
module sia_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = sia_pkg::QDEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          push, pop;

  assign in_ready  = (cnt_r != (AW+1)'(DEPTH));
  assign out_valid = (cnt_r != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

/* design/sia_div.sv */
// Pipelined restoring divider: one quotient bit per stage, range check at the end.
module sia_div #(
  parameter int FRAC_BITS = sia_pkg::FRAC_BITS_DEF,
  parameter int NW        = sia_pkg::PW - FRAC_BITS + 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [NW-1:0] den,
  output logic [FRAC_BITS:0]   quo,
  output logic                 ok
);
  localparam int NS = FRAC_BITS + 2;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic [NW-1:0]      r_r   [NS];
  logic [NW-1:0]      d_r   [NS];
  logic [FRAC_BITS:0] q_r   [NS];
  logic               bad_r [NS];
  logic               neg_r [NS];

  // stage 0: magnitudes and sign of the quotient
  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= num[NW-1] ? NW'(-num) : NW'(num);
      d_r[0]   <= den[NW-1] ? NW'(-den) : NW'(den);
      q_r[0]   <= '0;
      bad_r[0] <= 1'b0;
      neg_r[0] <= num[NW-1] ^ den[NW-1];
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_st
    logic [NW:0]        r2;
    logic               ge;
    logic [NW-1:0]      r_nxt;
    logic [FRAC_BITS:0] q_nxt;
    logic               bad_nxt;

    if (k == 1) begin : g_int
      // integer part: two or more means out of range, zero divisor lands here too
      always_comb begin
        r2      = {1'b0, r_r[0]};
        ge      = r_r[0] >= d_r[0];
        bad_nxt = r2 >= ({1'b0, d_r[0]} << 1);
        r_nxt   = ge ? r_r[0] - d_r[0] : r_r[0];
        q_nxt   = (FRAC_BITS+1)'(ge);
      end
    end else begin : g_frac
      always_comb begin
        r2      = {r_r[k-1], 1'b0};
        ge      = r2 >= {1'b0, d_r[k-1]};
        bad_nxt = bad_r[k-1];
        r_nxt   = ge ? NW'(r2 - {1'b0, d_r[k-1]}) : NW'(r2);
        q_nxt   = {q_r[k-1][FRAC_BITS-1:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]   <= r_nxt;
        d_r[k]   <= d_r[k-1];
        q_r[k]   <= q_nxt;
        bad_r[k] <= bad_nxt;
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  assign quo = q_r[NS-1];
  assign ok  = !bad_r[NS-1] && !((q_r[NS-1] != '0) && neg_r[NS-1]) && (q_r[NS-1] <= ONE);

endmodule

/* design/sia_front.sv */
// Front section: differences, six exact products, numerators and denominator.
module sia_front #(
  parameter int FRAC_BITS = sia_pkg::FRAC_BITS_DEF,
  parameter int NW        = sia_pkg::PW - FRAC_BITS + 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [8*sia_pkg::XW-1:0]  in_data,
  output logic                      q_valid,
  input  logic                      q_ready,
  output logic signed [NW-1:0]      ua_num,
  output logic signed [NW-1:0]      ub_num,
  output logic signed [NW-1:0]      den,
  output sia_pkg::pay_t             pay
);
  import sia_pkg::*;

  coord_t x1, y1, x2, y2, x3, y3, x4, y4;
  diff_t  dbx_r, dby_r, ox_r, oy_r;
  pay_t   pay_r [4];
  logic   v_r   [4];
  logic   en;
  logic signed [PW-1:0] p_ua1, p_ua2, p_ub1, p_ub2, p_d1, p_d2;
  logic signed [NW-1:0] ua_r, ub_r, den_r;

  assign x1 = $signed(in_data[0*XW +: XW]);
  assign y1 = $signed(in_data[1*XW +: XW]);
  assign x2 = $signed(in_data[2*XW +: XW]);
  assign y2 = $signed(in_data[3*XW +: XW]);
  assign x3 = $signed(in_data[4*XW +: XW]);
  assign y3 = $signed(in_data[5*XW +: XW]);
  assign x4 = $signed(in_data[6*XW +: XW]);
  assign y4 = $signed(in_data[7*XW +: XW]);

  assign en       = !v_r[3] || q_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (en) begin
      pay_r[0].x1  <= x1;
      pay_r[0].y1  <= y1;
      pay_r[0].dax <= DW'(x2) - DW'(x1);
      pay_r[0].day <= DW'(y2) - DW'(y1);
      dbx_r        <= DW'(x4) - DW'(x3);
      dby_r        <= DW'(y4) - DW'(y3);
      ox_r         <= DW'(x1) - DW'(x3);
      oy_r         <= DW'(y1) - DW'(y3);
      pay_r[1]     <= pay_r[0];
      pay_r[2]     <= pay_r[1];
      pay_r[3]     <= pay_r[2];
      // floor shift of each exact product, then the difference
      ua_r  <= NW'($signed(p_ua1[PW-1:FRAC_BITS])) - NW'($signed(p_ua2[PW-1:FRAC_BITS]));
      ub_r  <= NW'($signed(p_ub1[PW-1:FRAC_BITS])) - NW'($signed(p_ub2[PW-1:FRAC_BITS]));
      den_r <= NW'($signed(p_d1[PW-1:FRAC_BITS]))  - NW'($signed(p_d2[PW-1:FRAC_BITS]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      v_r[1] <= v_r[0];
      v_r[2] <= v_r[1];
      v_r[3] <= v_r[2];
    end
  end

  sia_mul u_mul_ua1 (.clk(clk), .en(en), .a(dbx_r),        .b(oy_r),         .p(p_ua1));
  sia_mul u_mul_ua2 (.clk(clk), .en(en), .a(dby_r),        .b(ox_r),         .p(p_ua2));
  sia_mul u_mul_ub1 (.clk(clk), .en(en), .a(pay_r[0].dax), .b(oy_r),         .p(p_ub1));
  sia_mul u_mul_ub2 (.clk(clk), .en(en), .a(pay_r[0].day), .b(ox_r),         .p(p_ub2));
  sia_mul u_mul_d1  (.clk(clk), .en(en), .a(dby_r),        .b(pay_r[0].dax), .p(p_d1));
  sia_mul u_mul_d2  (.clk(clk), .en(en), .a(dbx_r),        .b(pay_r[0].day), .p(p_d2));

  assign q_valid = v_r[3];
  assign ua_num  = ua_r;
  assign ub_num  = ub_r;
  assign den     = den_r;
  assign pay     = pay_r[3];

endmodule

/* design/sia_back.sv */
// Back section: two parameter dividers, range test, interpolation and output register.
module sia_back #(
  parameter int FRAC_BITS = sia_pkg::FRAC_BITS_DEF,
  parameter int NW        = sia_pkg::PW - FRAC_BITS + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  logic signed [NW-1:0] ua_num,
  input  logic signed [NW-1:0] ub_num,
  input  logic signed [NW-1:0] den,
  input  sia_pkg::pay_t        pay,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output sia_pkg::coord_t      cross_x,
  output sia_pkg::coord_t      cross_y
);
  import sia_pkg::*;

  localparam int LD = FRAC_BITS + 2;
  localparam int LW = FRAC_BITS + 2 + DW;
  localparam logic signed [LW-1:0] HALF = LW'(1) << (FRAC_BITS - 1);

  logic               en;
  logic               v_r   [LD];
  pay_t               pay_r [LD];
  logic [FRAC_BITS:0] qa, qb;
  logic               oka, okb;
  logic               vm_r, hitm_r;
  coord_t             xm_r, ym_r;
  logic signed [LW-1:0] px_r, py_r, ux, uy, shx, shy;
  logic               out_v_r, hit_r;
  coord_t             cx_r, cy_r;

  assign en      = !out_v_r || out_ready;
  assign q_ready = en;

  sia_div #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_div_a (
    .clk(clk), .en(en), .num(ua_num), .den(den), .quo(qa), .ok(oka)
  );
  sia_div #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_div_b (
    .clk(clk), .en(en), .num(ub_num), .den(den), .quo(qb), .ok(okb)
  );

  assign ux  = px_r + HALF;
  assign uy  = py_r + HALF;
  assign shx = ux >>> FRAC_BITS;
  assign shy = uy >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      pay_r[0] <= pay;
      for (int i = 1; i < LD; i++) pay_r[i] <= pay_r[i-1];
      hitm_r  <= oka && okb;
      xm_r    <= pay_r[LD-1].x1;
      ym_r    <= pay_r[LD-1].y1;
      px_r    <= $signed({1'b0, qa}) * pay_r[LD-1].dax;
      py_r    <= $signed({1'b0, qa}) * pay_r[LD-1].day;
      hit_r   <= hitm_r;
      cx_r    <= hitm_r ? XW'(xm_r + shx[XW-1:0]) : '0;
      cy_r    <= hitm_r ? XW'(ym_r + shy[XW-1:0]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LD; i++) v_r[i] <= 1'b0;
      vm_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= q_valid;
      for (int i = 1; i < LD; i++) v_r[i] <= v_r[i-1];
      vm_r    <= v_r[LD-1];
      out_v_r <= vm_r;
    end
  end

  assign out_valid = out_v_r;
  assign hit       = hit_r;
  assign cross_x   = cx_r;
  assign cross_y   = cy_r;

endmodule

/* design/segment_intersection_q16_unit.sv */
// Top level of the fixed-point segment intersection unit.
// Input stream: one transfer carries two segments, eight signed coordinates with
// FRAC_BITS fraction bits. Output stream: one transfer per input, with the hit
// flag in out_tuser and the crossing point (zero on a miss) in out_tdata.
// Throughput: one segment pair per cycle, sustained, as long as the output is
// taken; every stage of both sections is fully pipelined.
// Path from input transfer to out_tvalid: the front section (differences,
// two-stage products, numerator and denominator), the queue, the bit-per-stage
// dividers, and the interpolation multiply and the rounded add.
// A 4-entry queue separates the front from the back. When the receiver holds
// out_tready low while out_tvalid is high, the back section freezes in place;
// the front keeps accepting until the queue fills, then in_tready drops.
// Reset (rst_n low at a clock edge) empties every pipeline and the queue; no
// item in flight survives it.
module segment_intersection_q16_unit #(
  parameter int FRAC_BITS = sia_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [8*sia_pkg::XW-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // cross_x, cross_y
  output logic [2*sia_pkg::XW-1:0]   out_tdata,
  // hit
  output logic [0:0]                 out_tuser
);
  import sia_pkg::*;

  localparam int NW = PW - FRAC_BITS + 1;
  localparam int FW = 3 * NW + $bits(pay_t);

  logic                 f_valid, f_ready, b_valid, b_ready, hit;
  logic signed [NW-1:0] f_ua, f_ub, f_den, b_ua, b_ub, b_den;
  pay_t                 f_pay, b_pay;
  logic [FW-1:0]        f_data, b_data;
  coord_t               cross_x, cross_y;

  sia_front #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_data(in_tdata),
    .q_valid(f_valid), .q_ready(f_ready),
    .ua_num(f_ua), .ub_num(f_ub), .den(f_den), .pay(f_pay)
  );

  assign f_data = {f_ua, f_ub, f_den, f_pay};

  sia_fifo #(.W(FW), .DEPTH(QDEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
  );

  assign {b_ua, b_ub, b_den, b_pay} = b_data;

  sia_back #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(b_valid), .q_ready(b_ready),
    .ua_num(b_ua), .ub_num(b_ub), .den(b_den), .pay(b_pay),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .hit(hit), .cross_x(cross_x), .cross_y(cross_y)
  );

  assign out_tdata = {cross_y, cross_x};
  assign out_tuser = hit;

endmodule

/* design/sia_checker.sv */
// Port-level checker for the segment intersection unit, bound to the top level.
`include "segment_intersection_q16_unit_assert.svh"

module sia_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [2*sia_pkg::XW-1:0] out_tdata,
  input logic [0:0]               out_tuser
);

  `SIA_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "stalled result dropped")
  `SIA_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `SIA_ASSERT(a_miss_zero, out_tvalid && !out_tuser[0] |-> out_tdata == '0, "miss with nonzero point")
  `SIA_ASSERT_RST(a_rst_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind segment_intersection_q16_unit sia_checker u_sia_checker (.*);
